>>> design/gtp_pkg.sv
// Shared types, constants and the arctangent table for the go-to-point block.
// No dependencies; every other design file uses this package by scoped names.
`default_nettype none
package gtp_pkg;

    localparam int POS_BITS     = 16;
    localparam int DX_BITS      = POS_BITS + 1;
    localparam int D2_BITS      = 2 * DX_BITS;
    localparam int SPEED_BITS   = 10;
    localparam int DIR_BITS     = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_BITS  = 62;
    localparam int CORDIC_TOP   = 60;
    localparam int ANG_BITS     = 25;
    localparam int ADDR_BITS    = 4;

    localparam logic [SPEED_BITS-1:0] SPEED_FULL   = 10'd500;
    localparam logic [SPEED_BITS-1:0] SLOW_DIST    = 10'd250;
    localparam logic [SPEED_BITS-1:0] RAMP_STEP    = 10'd20;
    localparam logic [SPEED_BITS-1:0] CIRCLE_SPEED = 10'd100;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_STRAIGHT = 2'd1;
    localparam logic [1:0] MODE_CIRCLE   = 2'd2;
    // unused encoding, behaves as idle
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_TARGET_Y = 2'd1;
    localparam logic [1:0] REG_WINDOW   = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic signed [15:0]         velocity_heading;
    } in_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0]      speed_cmd;
        logic signed [DIR_BITS-1:0] direction_cmd;
        logic                       done_res;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_LOAD,
        S_ITER,
        S_FIN
    } state_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic [ANG_BITS-1:0] atan_q16(input logic [4:0] idx);
        logic [ANG_BITS-1:0] v;
        unique case (idx)
            5'd0:    v = 25'd2949120;
            5'd1:    v = 25'd1740967;
            5'd2:    v = 25'd919879;
            5'd3:    v = 25'd466945;
            5'd4:    v = 25'd234379;
            5'd5:    v = 25'd117304;
            5'd6:    v = 25'd58666;
            5'd7:    v = 25'd29335;
            5'd8:    v = 25'd14668;
            5'd9:    v = 25'd7334;
            5'd10:   v = 25'd3667;
            5'd11:   v = 25'd1833;
            5'd12:   v = 25'd917;
            5'd13:   v = 25'd458;
            5'd14:   v = 25'd229;
            5'd15:   v = 25'd115;
            5'd16:   v = 25'd57;
            5'd17:   v = 25'd29;
            5'd18:   v = 25'd14;
            5'd19:   v = 25'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> design/gtp_isqrt.sv
// Restoring integer square root, two radicand bits per cycle.
// Depends on gtp_pkg for widths.
`default_nettype none
module gtp_isqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [gtp_pkg::D2_BITS-1:0]  radicand,
    output logic      [gtp_pkg::DX_BITS-1:0]  root,
    output logic                              busy
);
    localparam int RW = gtp_pkg::DX_BITS;
    localparam int CNT_BITS = $clog2(RW + 1);

    logic [2*RW-1:0]     rad_reg;
    logic [RW:0]         rem_reg;
    logic [RW-1:0]       root_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;

    logic [RW+2:0] r_next;
    logic [RW+2:0] trial;
    logic          fits;

    assign r_next = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (r_next >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(RW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[2*RW-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= (RW+1)'(r_next - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= (RW+1)'(r_next);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign busy = busy_reg;

endmodule
`default_nettype wire

>>> design/gtp_cordic.sv
// Vectoring CORDIC, one iteration per cycle, angle accumulated in Q16 degrees.
// Depends on gtp_pkg for widths and the arctangent table.
`default_nettype none
module gtp_cordic (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic        [gtp_pkg::DX_BITS-1:0]  ax,
    input  wire logic        [gtp_pkg::DX_BITS-1:0]  ay,
    output logic signed      [gtp_pkg::ANG_BITS-1:0] angle,
    output logic                                     busy
);
    localparam int CW       = gtp_pkg::CORDIC_BITS;
    localparam int SHIFT    = gtp_pkg::CORDIC_TOP - gtp_pkg::DX_BITS;
    localparam int CNT_BITS = $clog2(gtp_pkg::CORDIC_STEPS);

    logic signed [CW-1:0]                 x_reg;
    logic signed [CW-1:0]                 y_reg;
    logic signed [gtp_pkg::ANG_BITS-1:0]  z_reg;
    logic [CNT_BITS-1:0]                  cnt_reg;
    logic                                 busy_reg;

    logic signed [CW-1:0]                xs;
    logic signed [CW-1:0]                ys;
    logic signed [gtp_pkg::ANG_BITS-1:0] step_ang;

    // shift toward zero
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                    input logic [CNT_BITS-1:0] s);
        logic [CW-1:0] mag;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        mag = mag >> s;
        return v[CW-1] ? signed'(CW'(-mag)) : signed'(mag);
    endfunction

    assign xs       = shr_tz(x_reg, cnt_reg);
    assign ys       = shr_tz(y_reg, cnt_reg);
    assign step_ang = signed'(gtp_pkg::atan_q16(5'(cnt_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(gtp_pkg::CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= signed'(CW'(ax) << SHIFT);
            y_reg <= signed'(CW'(ay) << SHIFT);
            z_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_ang;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_ang;
            end
        end
    end

    assign angle = z_reg;
    assign busy  = busy_reg;

endmodule
`default_nettype wire

>>> design/goto_point_speed_heading_step.sv
// Go-to-point speed and heading generator, one transaction per control tick.
// Sequence from input accept to result valid: square x, square y, load, then the
// iteration state, whose 20 CORDIC steps cover the 17-step square root, plus the
// done check, then finish. Output stalls hold the finish state.
// A new transaction is accepted only in the idle state, after the last result is loaded.
// Reset: async active low; config to 0, ramp to 0, running set, no result.
`default_nettype none
module goto_point_speed_heading_step (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire gtp_pkg::in_t                    in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output gtp_pkg::out_t                        out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [gtp_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready
);
    localparam int P   = gtp_pkg::POS_BITS;
    localparam int DXW = gtp_pkg::DX_BITS;
    localparam int D2W = gtp_pkg::D2_BITS;
    localparam int SW  = gtp_pkg::SPEED_BITS;
    localparam int DW  = gtp_pkg::DIR_BITS;
    localparam int CMPW = (D2W > 32) ? D2W : 32;

    // configuration registers
    logic signed [P-1:0] target_x_reg;
    logic signed [P-1:0] target_y_reg;
    logic [15:0]         window_reg;
    logic [1:0]          mode_reg;
    logic                running_reg;
    logic [SW-1:0]       ramp_reg;

    gtp_pkg::state_t state_reg, state_next;

    // per-tick working registers
    logic [DXW-1:0]  ax_reg, ay_reg;
    logic            dx_neg_reg, dy_neg_reg;
    logic [15:0]     vh_reg;
    logic [D2W-1:0]  sqx_reg, sqy_reg, d2_reg;
    logic [31:0]     w2_reg;

    logic            out_valid_reg;
    gtp_pkg::out_t   out_reg;

    // control strobes
    logic            wr_en;
    logic            accept;
    logic            unit_start;
    logic            res_load;
    logic            out_free;

    logic signed [DXW-1:0] dx, dy;
    logic [D2W-1:0]        d2_sum;

    logic [DXW-1:0]                 root;
    logic                           sqrt_busy;
    logic signed [gtp_pkg::ANG_BITS-1:0] angle;
    logic                           cordic_busy;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= '0;
            target_y_reg <= '0;
            window_reg   <= '0;
            mode_reg     <= gtp_pkg::MODE_IDLE;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                gtp_pkg::REG_TARGET_X: target_x_reg <= signed'(pwdata[P-1:0]);
                gtp_pkg::REG_TARGET_Y: target_y_reg <= signed'(pwdata[P-1:0]);
                gtp_pkg::REG_WINDOW:   window_reg   <= pwdata[15:0];
                gtp_pkg::REG_MODE:     mode_reg     <= pwdata[1:0];
                default:               mode_reg     <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gtp_pkg::REG_TARGET_X: prdata = 32'(target_x_reg);
            gtp_pkg::REG_TARGET_Y: prdata = 32'(target_y_reg);
            gtp_pkg::REG_WINDOW:   prdata = {16'd0, window_reg};
            gtp_pkg::REG_MODE:     prdata = {30'd0, mode_reg};
            default:               prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gtp_pkg::S_IDLE: if (in_valid && running_reg) state_next = gtp_pkg::S_SQX;
            gtp_pkg::S_SQX:  state_next = gtp_pkg::S_SQY;
            gtp_pkg::S_SQY:  state_next = gtp_pkg::S_LOAD;
            gtp_pkg::S_LOAD: state_next = gtp_pkg::S_ITER;
            gtp_pkg::S_ITER: if (!sqrt_busy && !cordic_busy) state_next = gtp_pkg::S_FIN;
            gtp_pkg::S_FIN:  if (out_free) state_next = gtp_pkg::S_IDLE;
            default:         state_next = gtp_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == gtp_pkg::S_IDLE);
        unit_start = (state_reg == gtp_pkg::S_LOAD);
        res_load   = (state_reg == gtp_pkg::S_FIN) && out_free;
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- operand capture and squares ----------------
    // a stopped block swallows the transaction: it still captures the operands but starts nothing
    assign dx = DXW'(target_x_reg) - DXW'(in_data.pos_x);
    assign dy = DXW'(target_y_reg) - DXW'(in_data.pos_y);
    assign d2_sum = sqx_reg + sqy_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg     <= dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
            ay_reg     <= dy[DXW-1] ? DXW'(-dy) : DXW'(dy);
            dx_neg_reg <= dx[DXW-1];
            dy_neg_reg <= dy[DXW-1];
            vh_reg     <= in_data.velocity_heading;
        end
        if (state_reg == gtp_pkg::S_SQX)
        begin
            sqx_reg <= D2W'(ax_reg) * D2W'(ax_reg);
        end
        if (state_reg == gtp_pkg::S_SQY)
        begin
            sqy_reg <= D2W'(ay_reg) * D2W'(ay_reg);
        end
        if (unit_start)
        begin
            d2_reg <= d2_sum;
            w2_reg <= 32'(window_reg) * 32'(window_reg);
        end
    end

    gtp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .radicand (d2_sum),
        .root     (root),
        .busy     (sqrt_busy)
    );

    gtp_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .ax    (ax_reg),
        .ay    (ay_reg),
        .angle (angle),
        .busy  (cordic_busy)
    );

    // ---------------- heading ----------------
    logic [7:0] fl_raw;
    logic [7:0] fl;
    logic [7:0] mag;
    logic signed [DW-1:0] heading;

    assign fl_raw = angle[gtp_pkg::ANG_BITS-1] ? 8'd0 : angle[23:16];
    assign fl     = (fl_raw > 8'd89) ? 8'd89 : fl_raw;

    always_comb
    begin
        priority if (ay_reg == '0)
        begin
            mag = dx_neg_reg ? 8'd180 : 8'd0;
        end
        else if (ax_reg == '0)
        begin
            mag = 8'd90;
        end
        else if (ax_reg == ay_reg)
        begin
            mag = dx_neg_reg ? 8'd135 : 8'd45;
        end
        else
        begin
            // 180 minus the ceiling, ceiling = floor + 1
            mag = dx_neg_reg ? 8'(8'd179 - fl) : fl;
        end
        heading = dy_neg_reg ? signed'(DW'(-DW'(mag))) : signed'(DW'(mag));
    end

    // ---------------- speed goal and ramp ----------------
    logic [SW-1:0]        goal;
    logic signed [DW-1:0] dir;
    logic                 in_window;
    logic                 arrive;
    logic [SW-1:0]        ramp_next;

    assign in_window = (CMPW'(d2_reg) < CMPW'(w2_reg));
    assign arrive    = in_window && (ramp_reg < gtp_pkg::RAMP_STEP);

    always_comb
    begin
        goal = '0;
        dir  = '0;
        unique case (mode_reg)
            gtp_pkg::MODE_STRAIGHT:
            begin
                dir  = heading;
                goal = (root < DXW'(gtp_pkg::SLOW_DIST)) ? SW'({root, 1'b0})
                                                         : gtp_pkg::SPEED_FULL;
            end
            gtp_pkg::MODE_CIRCLE:
            begin
                dir  = DW'(1);
                goal = gtp_pkg::CIRCLE_SPEED;
            end
            default:
            begin
                dir  = '0;
                goal = '0;
            end
        endcase
        if (in_window)
        begin
            goal = '0;
        end
        ramp_next = (goal >= ramp_reg) ? SW'(ramp_reg + gtp_pkg::RAMP_STEP)
                                       : SW'(ramp_reg - gtp_pkg::RAMP_STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg    <= '0;
            running_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            running_reg <= 1'b1;
        end
        else if (res_load)
        begin
            if (arrive)
            begin
                ramp_reg    <= gtp_pkg::RAMP_STEP;
                running_reg <= 1'b0;
            end
            else
            begin
                ramp_reg <= ramp_next;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (arrive)
            begin
                out_reg.speed_cmd     <= '0;
                out_reg.direction_cmd <= signed'(vh_reg);
                out_reg.done_res      <= 1'b1;
            end
            else
            begin
                out_reg.speed_cmd     <= ramp_next;
                out_reg.direction_cmd <= dir;
                out_reg.done_res      <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire
